// ===== design/largest_clear_square_scan_core_macros.svh =====
// Assertion macros for the largest clear square scan core.
// Used by lcss_tracker.sv; expects clk and rst_n in scope at the point of use.
`ifndef LARGEST_CLEAR_SQUARE_SCAN_CORE_MACROS_SVH
`define LARGEST_CLEAR_SQUARE_SCAN_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define LCSS_ASSERT_NOW(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition pre at one edge implies post at the next edge.
`define LCSS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define LCSS_ASSERT_NOW(label, expr, msg)
`define LCSS_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== design/lcss_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and the token type of the largest clear square scan core.
// No dependencies; imported by every module of the core.
package lcss_pkg;

    localparam int SIZE_W       = 9;     // square size width
    localparam int POS_W        = 8;     // reported row / column width
    localparam int SIDE_W       = 9;     // side length register width
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 40;
    localparam int SIDE_RESET   = 256;
    localparam int MAX_SIDE_DEF = 256;
    localparam int SIDE_LIMIT   = 511;   // largest side the register can hold

    localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

    // Pixel token that walks down the cell chain.
    typedef struct packed {
        logic              valid;
        logic              black;
        logic              first;   // first row or first column
        logic              last;    // last pixel of the frame
        logic [POS_W-1:0]  row;
        logic [SIZE_W-1:0] size;    // filled in by the cell owning the column
    } lcss_tok_t;

endpackage

// ===== design/lcss_cell.sv =====
`timescale 1ns / 1ps
// One column cell: holds the previous-row value of its column and one chain stage.
// Depends on lcss_pkg.
module lcss_cell
    import lcss_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int COL_W    = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  lcss_tok_t         tok_prev,
    input  logic [COL_W-1:0]  col_prev,
    input  logic [SIZE_W-1:0] left_cur,   // left cell: value just written this row
    input  logic [SIZE_W-1:0] left_old,   // left cell: value it replaced (diagonal)
    output lcss_tok_t         tok,
    output logic [COL_W-1:0]  col,
    output logic [SIZE_W-1:0] cur,
    output logic [SIZE_W-1:0] old
);

    lcss_tok_t         tok_reg, tok_next;
    logic [COL_W-1:0]  col_reg;
    logic [SIZE_W-1:0] cur_reg, cur_next;
    logic [SIZE_W-1:0] old_reg;
    logic [SIZE_W-1:0] min_ab, min_abc;
    logic [SIZE_W-1:0] size;
    logic              hit;

    assign hit = tok_prev.valid && (col_prev == COL_W'(CELL_IDX));

    always_comb
    begin
        min_ab  = (cur_reg < left_cur) ? cur_reg : left_cur;
        min_abc = (min_ab < left_old) ? min_ab : left_old;
        if (tok_prev.black)
        begin
            size = '0;
        end
        else if (tok_prev.first)
        begin
            size = SIZE_W'(1);
        end
        else if (min_abc == SIZE_SAT)
        begin
            size = SIZE_SAT;
        end
        else
        begin
            size = min_abc + SIZE_W'(1);
        end

        tok_next = tok_prev;
        cur_next = cur_reg;
        if (hit)
        begin
            tok_next.size = size;
            cur_next      = size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    // line values: undefined until written
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg <= col_prev;
            if (hit)
            begin
                old_reg <= cur_reg;
                cur_reg <= cur_next;
            end
        end
    end

    assign tok = tok_reg;
    assign col = col_reg;
    assign cur = cur_reg;
    assign old = old_reg;

endmodule

// ===== design/lcss_tracker.sv =====
`timescale 1ns / 1ps
// Frame maximum tracker and output register at the end of the cell chain.
// Depends on lcss_pkg and largest_clear_square_scan_core_macros.svh.
`include "largest_clear_square_scan_core_macros.svh"

module lcss_tracker
    import lcss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcss_tok_t              tok,
    input  logic [POS_W-1:0]       col,
    output logic                   adv,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // square_size, best_size, best_row, best_col
    output logic                   m_tlast    // frame_done
);

    logic              out_valid_reg;
    logic [SIZE_W-1:0] sq_reg;
    logic [SIZE_W-1:0] best_reg;
    logic [POS_W-1:0]  brow_reg;
    logic [POS_W-1:0]  bcol_reg;
    logic              last_reg;

    logic [SIZE_W-1:0] max_size_reg, max_size_next;
    logic [POS_W-1:0]  max_row_reg, max_row_next;
    logic [POS_W-1:0]  max_col_reg, max_col_next;
    logic              take;

    assign adv  = !out_valid_reg || m_tready;
    assign take = adv && tok.valid;

    // first position wins on ties
    always_comb
    begin
        max_size_next = max_size_reg;
        max_row_next  = max_row_reg;
        max_col_next  = max_col_reg;
        if (tok.size > max_size_reg)
        begin
            max_size_next = tok.size;
            max_row_next  = tok.row;
            max_col_next  = col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_size_reg  <= '0;
            max_row_reg   <= '0;
            max_col_reg   <= '0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= tok.valid;
            end
            if (take)
            begin
                if (tok.last)
                begin
                    max_size_reg <= '0;
                    max_row_reg  <= '0;
                    max_col_reg  <= '0;
                end
                else
                begin
                    max_size_reg <= max_size_next;
                    max_row_reg  <= max_row_next;
                    max_col_reg  <= max_col_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sq_reg   <= tok.size;
            best_reg <= max_size_next;
            brow_reg <= max_row_next;
            bcol_reg <= max_col_next;
            last_reg <= tok.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(OUT_TDATA_W - 2*SIZE_W - 2*POS_W)'(0),
                       bcol_reg, brow_reg, best_reg, sq_reg};

    `LCSS_ASSERT_NOW(a_best_covers_size, !m_tvalid || (best_reg >= sq_reg), "best_size below square_size")
    `LCSS_ASSERT_NOW(a_zero_best_at_origin, !(m_tvalid && best_reg == '0) || (brow_reg == '0 && bcol_reg == '0), "empty frame reports nonzero position")
    `LCSS_ASSERT_NEXT(a_frame_restart, take && tok.last, max_size_reg == '0 && max_row_reg == '0 && max_col_reg == '0, "maximum not cleared after frame end")

endmodule

// ===== design/largest_clear_square_scan_core.sv =====
`timescale 1ns / 1ps
// Largest clear square scan core: per-pixel maximal square size over a raster stream.
// Each column has one chain stage; the output register in the tracker follows the last cell.
// Throughput: one pixel per cycle; the whole cell chain advances together and stalls while a
// finished result sits unclaimed in the output register.
// Reset clears counters, frame maximum and chain valid bits and sets side length to 256; line values
// held in the cells are undefined until written by the first row of a frame.
// Depends on lcss_pkg, lcss_cell, lcss_tracker.
module largest_clear_square_scan_core
    import lcss_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: side length
    input  logic                   cfg_we,
    input  logic [SIDE_W-1:0]      cfg_wdata,
    // pixel stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // is_black, zero padding
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // square_size, best_size, best_row, best_col, padding
    output logic                   m_tlast     // frame_done
);

    // Side length can never pass the register range, so the chain needs no more cells.
    localparam int NUM_CELLS = (MAX_SIDE < SIDE_LIMIT) ? MAX_SIDE : SIDE_LIMIT;
    localparam int COL_W     = $clog2(NUM_CELLS);
    localparam int N_W       = $clog2(NUM_CELLS + 1);

    logic [SIDE_W-1:0] side_reg;
    logic [COL_W-1:0]  col_count_reg, col_count_next;
    logic [COL_W-1:0]  row_count_reg, row_count_next;

    logic [N_W-1:0]    n_eff;
    logic [N_W-1:0]    col_p1;
    logic [N_W-1:0]    row_p1;
    logic              row_end;
    logic              frame_end;
    logic              accept;
    logic              adv;
    logic [POS_W-1:0]  row_pos;
    logic [POS_W-1:0]  col_pos;

    lcss_tok_t         in_tok;
    lcss_tok_t         tok_s [NUM_CELLS];
    logic [COL_W-1:0]  col_s [NUM_CELLS];
    logic [SIZE_W-1:0] cur_s [NUM_CELLS];
    logic [SIZE_W-1:0] old_s [NUM_CELLS];

    // ------------------------------------------------------------------
    // Configuration: side length, zero treated as one, saturated to chain length
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_W'(SIDE_RESET);
        end
        else if (cfg_we)
        begin
            side_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (side_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (side_reg > SIDE_W'(NUM_CELLS))
        begin
            n_eff = N_W'(NUM_CELLS);
        end
        else
        begin
            n_eff = N_W'(side_reg);
        end
    end

    // ------------------------------------------------------------------
    // Raster position counters at the input
    // ------------------------------------------------------------------
    assign s_tready  = adv;
    assign accept    = s_tvalid && s_tready;
    assign col_p1    = N_W'(col_count_reg) + N_W'(1);
    assign row_p1    = N_W'(row_count_reg) + N_W'(1);
    assign row_end   = col_p1 >= n_eff;
    assign frame_end = row_end && (row_p1 >= n_eff);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_count_next = '0;
                row_count_next = '0;
            end
            else if (row_end)
            begin
                col_count_next = '0;
                row_count_next = row_count_reg + COL_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // reported positions are the low bits of the counters
    generate
        if (COL_W >= POS_W)
        begin : g_pos_trunc
            assign row_pos = row_count_reg[POS_W-1:0];
            assign col_pos = col_s[NUM_CELLS-1][POS_W-1:0];
        end
        else
        begin : g_pos_ext
            assign row_pos = {{(POS_W-COL_W){1'b0}}, row_count_reg};
            assign col_pos = {{(POS_W-COL_W){1'b0}}, col_s[NUM_CELLS-1]};
        end
    endgenerate

    always_comb
    begin
        in_tok.valid = s_tvalid;
        in_tok.black = s_tdata[0];
        in_tok.first = (row_count_reg == '0) || (col_count_reg == '0);
        in_tok.last  = frame_end;
        in_tok.row   = row_pos;
        in_tok.size  = '0;
    end

    // ------------------------------------------------------------------
    // Cell chain: a pixel of column c is resolved in cell c, where the
    // previous-row value of c lives; cell c-1 was already updated by the
    // left pixel ahead in the chain, giving left and diagonal values.
    // ------------------------------------------------------------------
    generate
        for (genvar k = 0; k < NUM_CELLS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                lcss_cell #(
                    .CELL_IDX (k),
                    .COL_W    (COL_W)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .adv      (adv),
                    .tok_prev (in_tok),
                    .col_prev (col_count_reg),
                    .left_cur ('0),
                    .left_old ('0),
                    .tok      (tok_s[k]),
                    .col      (col_s[k]),
                    .cur      (cur_s[k]),
                    .old      (old_s[k])
                );
            end
            else
            begin : g_body
                lcss_cell #(
                    .CELL_IDX (k),
                    .COL_W    (COL_W)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .adv      (adv),
                    .tok_prev (tok_s[k-1]),
                    .col_prev (col_s[k-1]),
                    .left_cur (cur_s[k-1]),
                    .left_old (old_s[k-1]),
                    .tok      (tok_s[k]),
                    .col      (col_s[k]),
                    .cur      (cur_s[k]),
                    .old      (old_s[k])
                );
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Frame maximum and output register
    // ------------------------------------------------------------------
    lcss_tracker u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok      (tok_s[NUM_CELLS-1]),
        .col      (col_pos),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
